@@ src/mbrtu_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the Modbus RTU frame checker.
// This file has no dependencies. Every other source file imports it.
`default_nettype none

package mbrtu_pkg;

    // This is the largest frame length that the byte counter can show.
    localparam int MAX_FRAME   = 256;
    localparam int CNT_W       = $clog2(MAX_FRAME + 1);
    localparam int FRAME_LEN_W = 9;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // These are the byte positions of the header fields within a frame.
    localparam logic [CNT_W-1:0] POS_UNIT_ID   = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_FUNCTION  = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_ADDR_HI   = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_ADDR_LO   = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_COUNT_HI  = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_COUNT_LO  = CNT_W'(5);
    // The CRC starts to cover bytes once two bytes sit in the delay line.
    localparam logic [CNT_W-1:0] CRC_START_POS = CNT_W'(2);
    localparam logic [CNT_W-1:0] MIN_CHECKED   = CNT_W'(8);
    localparam logic [CNT_W-1:0] MAX_COUNT     = CNT_W'(MAX_FRAME);

    // These are the status codes of a result.
    localparam logic [2:0] ST_UNCHECKED    = 3'd0;
    localparam logic [2:0] ST_VALID        = 3'd1;
    localparam logic [2:0] ST_BAD_FUNCTION = 3'd2;
    localparam logic [2:0] ST_BAD_CRC      = 3'd3;
    localparam logic [2:0] ST_BAD_BOTH     = 3'd4;

    // These are the accepted Modbus function codes.
    localparam logic [7:0] FN_FIRST_BASIC = 8'd1;
    localparam logic [7:0] FN_LAST_BASIC  = 8'd6;
    localparam logic [7:0] FN_WRITE_COILS = 8'd15;
    localparam logic [7:0] FN_WRITE_REGS  = 8'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [7:0]             unit_id;
        logic [7:0]             function_code;
        logic [15:0]            start_address;
        logic [15:0]            item_count;
        logic [FRAME_LEN_W-1:0] frame_length;
        logic [15:0]            received_crc;
        logic [15:0]            computed_crc;
    } out_t;

    // This is the reflected CRC-16 update for one byte, unrolled over eight bit steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic function_good(input logic [7:0] f);
        return ((f >= FN_FIRST_BASIC) && (f <= FN_LAST_BASIC))
            || (f == FN_WRITE_COILS) || (f == FN_WRITE_REGS);
    endfunction

endpackage

`default_nettype wire

@@ src/modbus_rtu_frame_checker_unit.sv @@
// Top level of the Modbus RTU frame checker. It holds the input register, the output register
// and the configuration register. It depends on mbrtu_pkg and mbrtu_frame_core.
//
// Usage:
// - The s_ channel carries one received frame byte per request, with last_byte set on the
//   final byte of the frame. The m_ channel gives one result request per frame. That result
//   holds the status, the captured header, the frame length, the received CRC and the
//   computed CRC.
// - cfg_wr_en with cfg_wr_data writes check_enable in the same cycle. It should change only
//   while no frame is in flight.
// - A final byte is held in the input register and its result in the output register.
// - Throughput: one byte per cycle unless a final byte waits on a full output register. The
//   frame state goes through one unrolled eight-bit CRC step between the input and the output register.
// - Reset (aresetn low, synchronous) empties both registers, disables checking and clears
//   the frame state: the CRC returns to its seed and the counter and the header to zero.
// - When the receiver stalls, the result waits in the output register. Bytes that are not
//   final keep flowing and only update the frame state. A final byte waits in the input
//   register until the output register frees, and s_ready stays low while it waits.
`default_nettype none

module modbus_rtu_frame_checker_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output      logic            s_ready,
    input  wire mbrtu_pkg::in_t  s_item,
    output      logic            m_valid,
    input  wire logic            m_ready,
    output      mbrtu_pkg::out_t m_item,
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_wr_data
);
    import mbrtu_pkg::*;

    logic in_valid_reg;
    in_t  in_item_reg;
    logic out_valid_reg;
    out_t out_item_reg;
    logic check_enable_reg;

    logic out_free;
    logic advance;
    out_t core_result;

    // The output register can take a new result if it is empty or is being read this cycle.
    assign out_free = !out_valid_reg || m_ready;
    // A byte that is not final never needs the output register, so it always moves on.
    assign advance  = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    mbrtu_frame_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .item         (in_item_reg),
        .check_enable (check_enable_reg),
        .result       (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            check_enable_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                check_enable_reg <= cfg_wr_data;
            end

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance && in_item_reg.last_byte) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && in_item_reg.last_byte) begin
            out_item_reg <= core_result;
        end
    end

endmodule

`default_nettype wire

@@ src/mbrtu_frame_core.sv @@
// Frame state and per-byte processing: the running CRC, the delay line, the header capture and the result.
// This file depends on mbrtu_pkg.
`default_nettype none

module mbrtu_frame_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step,
    input  wire mbrtu_pkg::in_t item,
    input  wire logic           check_enable,
    output mbrtu_pkg::out_t     result
);
    import mbrtu_pkg::*;

    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       id_reg, id_next;
    logic [7:0]       fn_reg, fn_next;
    logic [15:0]      addr_reg, addr_next;
    logic [15:0]      count_reg, count_next;

    logic [15:0]      crc_cur;
    logic [CNT_W-1:0] cnt_inc;
    logic [15:0]      rx_crc;
    logic [15:0]      cx_crc;
    logic             crc_ok;
    logic             fn_ok;

    always_comb begin
        crc_cur = (cnt_reg >= CRC_START_POS) ? crc_byte(crc_reg, held0_reg) : crc_reg;
        cnt_inc = (cnt_reg < MAX_COUNT) ? cnt_reg + CNT_W'(1) : cnt_reg;

        id_next    = id_reg;
        fn_next    = fn_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        case (cnt_reg)
            POS_UNIT_ID:  id_next          = item.data_byte;
            POS_FUNCTION: fn_next          = item.data_byte;
            POS_ADDR_HI:  addr_next[15:8]  = item.data_byte;
            POS_ADDR_LO:  addr_next[7:0]   = item.data_byte;
            POS_COUNT_HI: count_next[15:8] = item.data_byte;
            POS_COUNT_LO: count_next[7:0]  = item.data_byte;
            default: begin
            end
        endcase

        rx_crc = {held1_reg, item.data_byte};
        cx_crc = {crc_cur[7:0], crc_cur[15:8]};
        crc_ok = (rx_crc == cx_crc);
        fn_ok  = function_good(fn_next);

        if (!check_enable || (cnt_inc < MIN_CHECKED)) begin
            result.status = ST_UNCHECKED;
        end else if (crc_ok) begin
            result.status = fn_ok ? ST_VALID : ST_BAD_FUNCTION;
        end else begin
            result.status = fn_ok ? ST_BAD_CRC : ST_BAD_BOTH;
        end
        result.unit_id       = id_next;
        result.function_code = fn_next;
        result.start_address = addr_next;
        result.item_count    = count_next;
        result.frame_length  = FRAME_LEN_W'(cnt_inc);
        result.received_crc  = rx_crc;
        result.computed_crc  = cx_crc;

        // The final byte closes the frame and clears everything for the next one.
        if (item.last_byte) begin
            crc_next   = CRC_SEED;
            held0_next = 8'h00;
            held1_next = 8'h00;
            cnt_next   = '0;
            id_next    = 8'h00;
            fn_next    = 8'h00;
            addr_next  = 16'h0000;
            count_next = 16'h0000;
        end else begin
            crc_next   = crc_cur;
            held0_next = held1_reg;
            held1_next = item.data_byte;
            cnt_next   = cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= CRC_SEED;
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
            cnt_reg   <= '0;
            id_reg    <= 8'h00;
            fn_reg    <= 8'h00;
            addr_reg  <= 16'h0000;
            count_reg <= 16'h0000;
        end else if (step) begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            cnt_reg   <= cnt_next;
            id_reg    <= id_next;
            fn_reg    <= fn_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ test/modbus_rtu_frame_checker_unit_test.sv @@
// Self-checking testbench for modbus_rtu_frame_checker_unit: frames of bytes go in, one
// result per frame comes out and is compared with a frame predictor kept in this file.
// Depends on mbrtu_pkg and the RTL of modbus_rtu_frame_checker_unit.
`timescale 1ns / 1ps

module modbus_rtu_frame_checker_unit_test;
    import mbrtu_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 3000;

    // Receiver pacing modes, switched at random intervals.
    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_HALF,
        PACE_SPARSE,
        PACE_MOSTLY
    } rx_pace_e;

    logic aclk        = 1'b0;
    logic aresetn     = 1'b0;
    logic s_valid     = 1'b0;
    logic s_ready;
    in_t  s_item      = '0;
    logic m_valid;
    logic m_ready     = 1'b0;
    out_t m_item;
    logic cfg_wr_en   = 1'b0;
    logic cfg_wr_data = 1'b0;

    modbus_rtu_frame_checker_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bytes waiting to be offered, and the results that the predictor expects, oldest first.
    in_t  pending_bytes[$];
    out_t frame_results[$];
    logic [7:0] frame_buf[$];
    int   bytes_queued;
    int   errors = 0;

    // Predictor state: it mirrors what the block keeps for the frame in progress.
    logic             check_on;
    logic [15:0]      crc_run;
    logic [7:0]       delay_old;
    logic [7:0]       delay_new;
    logic [CNT_W-1:0] bytes_seen;
    logic [7:0]       hdr_unit;
    logic [7:0]       hdr_func;
    logic [15:0]      hdr_addr;
    logic [15:0]      hdr_count;

    // The CRC is shifted one data bit at a time, LSB first, with the polynomial folded in.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic is_listed_function(input logic [7:0] f);
        case (f)
            FN_WRITE_COILS, FN_WRITE_REGS: return 1'b1;
            default: return (f >= FN_FIRST_BASIC) && (f <= FN_LAST_BASIC);
        endcase
    endfunction

    task automatic clear_frame_model();
        crc_run    = CRC_SEED;
        delay_old  = 8'h00;
        delay_new  = 8'h00;
        bytes_seen = '0;
        hdr_unit   = 8'h00;
        hdr_func   = 8'h00;
        hdr_addr   = 16'h0000;
        hdr_count  = 16'h0000;
    endtask

    // Advances the frame state by one accepted byte, and on the final byte queues the result.
    task automatic predict_frame_byte(input in_t req);
        out_t res;
        // The byte that leaves the two-byte delay is part of the body.
        if (bytes_seen >= CRC_START_POS) begin
            crc_run = crc16_update(crc_run, delay_old);
        end
        case (bytes_seen)
            POS_UNIT_ID:  hdr_unit         = req.data_byte;
            POS_FUNCTION: hdr_func         = req.data_byte;
            POS_ADDR_HI:  hdr_addr[15:8]   = req.data_byte;
            POS_ADDR_LO:  hdr_addr[7:0]    = req.data_byte;
            POS_COUNT_HI: hdr_count[15:8]  = req.data_byte;
            POS_COUNT_LO: hdr_count[7:0]   = req.data_byte;
            default: ;
        endcase
        if (bytes_seen < MAX_COUNT) begin
            bytes_seen = bytes_seen + 1'b1;
        end
        if (!req.last_byte) begin
            delay_old = delay_new;
            delay_new = req.data_byte;
        end else begin
            res.unit_id       = hdr_unit;
            res.function_code = hdr_func;
            res.start_address = hdr_addr;
            res.item_count    = hdr_count;
            res.frame_length  = bytes_seen;
            res.received_crc  = {delay_new, req.data_byte};
            res.computed_crc  = {crc_run[7:0], crc_run[15:8]};
            if (!check_on || bytes_seen < MIN_CHECKED) begin
                res.status = ST_UNCHECKED;
            end else if (res.received_crc == res.computed_crc) begin
                res.status = is_listed_function(hdr_func) ? ST_VALID : ST_BAD_FUNCTION;
            end else begin
                res.status = is_listed_function(hdr_func) ? ST_BAD_CRC : ST_BAD_BOTH;
            end
            frame_results.push_back(res);
            clear_frame_model();
        end
    endtask

    task automatic check_result(input out_t want, input out_t got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.unit_id !== want.unit_id) begin
            $error("unit_id: expected %0h, got %0h", want.unit_id, got.unit_id);
            errors++;
        end
        if (got.function_code !== want.function_code) begin
            $error("function_code: expected %0h, got %0h", want.function_code,
                   got.function_code);
            errors++;
        end
        if (got.start_address !== want.start_address) begin
            $error("start_address: expected %0h, got %0h", want.start_address,
                   got.start_address);
            errors++;
        end
        if (got.item_count !== want.item_count) begin
            $error("item_count: expected %0h, got %0h", want.item_count, got.item_count);
            errors++;
        end
        if (got.frame_length !== want.frame_length) begin
            $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
            errors++;
        end
        if (got.received_crc !== want.received_crc) begin
            $error("received_crc: expected %0h, got %0h", want.received_crc, got.received_crc);
            errors++;
        end
        if (got.computed_crc !== want.computed_crc) begin
            $error("computed_crc: expected %0h, got %0h", want.computed_crc, got.computed_crc);
            errors++;
        end
    endtask

    // Turns frame_buf into byte requests. The CRC goes out low byte first, as on the wire, and
    // a spoiled frame has one byte damaged after the CRC was taken.
    task automatic post_frame(input bit with_crc, input bit spoil);
        logic [15:0] c;
        int          pos;
        in_t         req;
        if (with_crc) begin
            c = CRC_SEED;
            foreach (frame_buf[i]) begin
                c = crc16_update(c, frame_buf[i]);
            end
            frame_buf.push_back(c[7:0]);
            frame_buf.push_back(c[15:8]);
        end
        if (spoil) begin
            pos = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
        end
        foreach (frame_buf[i]) begin
            req.data_byte = frame_buf[i];
            req.last_byte = (i == frame_buf.size() - 1);
            pending_bytes.push_back(req);
        end
        bytes_queued += frame_buf.size();
        frame_buf.delete();
    endtask

    function automatic logic [7:0] pick_listed_function();
        int k;
        k = $urandom_range(0, 7);
        if (k < 6) begin
            return FN_FIRST_BASIC + 8'(k);
        end else if (k == 6) begin
            return FN_WRITE_COILS;
        end
        return FN_WRITE_REGS;
    endfunction

    task automatic fill_random_body(input int n);
        repeat (n) begin
            frame_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly well-formed requests with random content; the rest are short frames and noise.
    task automatic queue_random_bytes(input int n);
        int kind;
        bytes_queued = 0;
        while (bytes_queued < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                fill_random_body($urandom_range(6, 18));
                if ($urandom_range(0, 9) != 0) begin
                    frame_buf[1] = pick_listed_function();
                end
                post_frame(1'b1, $urandom_range(0, 4) == 0);
            end else if (kind < 80) begin
                fill_random_body($urandom_range(1, 7));
                post_frame(1'b0, 1'b0);
            end else begin
                fill_random_body($urandom_range(1, 24));
                post_frame($urandom_range(0, 3) == 0, 1'b0);
            end
        end
    endtask

    // A frame of len bytes with a correct CRC, used around the counter's saturation point.
    task automatic queue_long_frame(input int len);
        fill_random_body(len - 2);
        frame_buf[1] = pick_listed_function();
        post_frame(1'b1, 1'b0);
    endtask

    task automatic write_check_enable(input logic en);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        check_on     = en;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // Waits until every byte is accepted and every result has arrived, then lets the
    // pipeline settle before anything else happens.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_bytes.size() != 0 || s_valid || frame_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Sender: bursts of requests separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_frame_byte(s_item);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    s_item  <= pending_bytes.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                                 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a pacing mode that changes now and then, plus a long hold-off on request.
    int       hold_off_reqs = 0;
    int       hold_off_seen;
    int       hold_left;
    int       pace_left;
    rx_pace_e rx_pace;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            hold_off_seen = 0;
            hold_left     = 0;
            pace_left     = 0;
            rx_pace       = PACE_FULL;
        end else begin
            if (hold_off_seen != hold_off_reqs) begin
                hold_off_seen = hold_off_reqs;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (pace_left == 0) begin
                    rx_pace   = rx_pace_e'($urandom_range(0, 3));
                    pace_left = $urandom_range(10, 200);
                end
                pace_left--;
                case (rx_pace)
                    PACE_FULL:   m_ready <= 1'b1;
                    PACE_HALF:   m_ready <= ($urandom_range(0, 1) == 0);
                    PACE_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_results.size() == 0) begin
                $error("result request with no frame outstanding");
                errors++;
            end else begin
                check_result(frame_results.pop_front(), m_item);
            end
        end
    end

    // Watchdog on cycles without any accepted request.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        check_on = 1'b0;
        clear_frame_model();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Checking is off after reset: a one-byte frame and a full frame, both unchecked.
        frame_buf = {8'hFF};
        post_frame(1'b0, 1'b0);
        frame_buf = {8'hFF, 8'h10, 8'hFF, 8'hFF, 8'h00, 8'h00};
        post_frame(1'b1, 1'b0);
        wait_drained();

        // Checking on: a good minimum-length frame and a damaged one with an unknown function.
        write_check_enable(1'b1);
        frame_buf = {8'h00, FN_WRITE_REGS, 8'h00, 8'h00, 8'hFF, 8'hFF};
        post_frame(1'b1, 1'b0);
        frame_buf = {8'h7F, 8'h00, 8'h80, 8'h01, 8'h00, 8'h02};
        post_frame(1'b1, 1'b1);
        wait_drained();

        // The receiver holds off for a long stretch while bytes keep coming, so the block
        // fills and has to stall its input.
        hold_off_reqs <= hold_off_reqs + 1;
        queue_random_bytes(250);
        wait_drained();

        write_check_enable(1'b0);
        queue_random_bytes(150);
        queue_long_frame(260);
        queue_random_bytes(100);
        wait_drained();

        // Frames right at and just past the saturation point of the byte counter.
        write_check_enable(1'b1);
        queue_long_frame(256);
        queue_random_bytes(150);
        queue_long_frame(257);
        queue_random_bytes(100);
        wait_drained();

        if (errors == 0 && frame_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
